/* hdl/hgp_pkg.sv */
package hgp_pkg;

   localparam int FREQ_W     = 14;
   localparam int DB_W       = 12;
   localparam int TRIM_W     = 10;
   localparam int GAIN_W     = 12;
   localparam int RATIO_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // nal-r numerator, doubled and offset by half the divisor
   localparam int NAL_X_W = 19;
   localparam int BASE_W  = 10;

   localparam int F_LOW    = 250;
   localparam int F_MID    = 500;
   localparam int F_KHZ    = 1000;
   localparam int F_2KHZ   = 2000;
   localparam int F_TREBLE = 4000;

   localparam int POGO_LOW = 160;
   localparam int POGO_MID = 80;
   localparam int GAIN_CAP = 512;
   localparam int GAIN_MAX = 560;
   localparam int SIM_CAP  = 1120;

   // floor(x / 200) for 0 <= x < NAL_SAT_X: shift by 3, then by 25 via reciprocal
   localparam int NAL_SAT_X   = 200 * (GAIN_CAP + 1);
   localparam int DIV25_MUL   = 20972;
   localparam int DIV25_SHIFT = 19;
   localparam int DIV25_IN_W  = 14;
   localparam int DIV25_PROD_W = DIV25_IN_W + 15;

   // floor(w / 5) for w < 2^12
   localparam int DIV5_MUL    = 3277;
   localparam int DIV5_SHIFT  = 14;
   localparam int DIV5_IN_W   = 12;
   localparam int DIV5_PROD_W = 24;
   localparam int SCALE_Z_W   = 14;

   localparam int RATIO_MIN = 16;
   localparam int RATIO_MAX = 56;
   localparam int RATIO_NUM = 33280;
   localparam int N_TH      = RATIO_MAX - RATIO_MIN;
   localparam int TH_W      = 11;

   // ratio reaches 17 + i while range <= RATIO_TH[i]
   localparam logic [TH_W-1:0] RATIO_TH [N_TH] = '{
      TH_W'(RATIO_NUM / 33),  TH_W'(RATIO_NUM / 35),  TH_W'(RATIO_NUM / 37),
      TH_W'(RATIO_NUM / 39),  TH_W'(RATIO_NUM / 41),  TH_W'(RATIO_NUM / 43),
      TH_W'(RATIO_NUM / 45),  TH_W'(RATIO_NUM / 47),  TH_W'(RATIO_NUM / 49),
      TH_W'(RATIO_NUM / 51),  TH_W'(RATIO_NUM / 53),  TH_W'(RATIO_NUM / 55),
      TH_W'(RATIO_NUM / 57),  TH_W'(RATIO_NUM / 59),  TH_W'(RATIO_NUM / 61),
      TH_W'(RATIO_NUM / 63),  TH_W'(RATIO_NUM / 65),  TH_W'(RATIO_NUM / 67),
      TH_W'(RATIO_NUM / 69),  TH_W'(RATIO_NUM / 71),  TH_W'(RATIO_NUM / 73),
      TH_W'(RATIO_NUM / 75),  TH_W'(RATIO_NUM / 77),  TH_W'(RATIO_NUM / 79),
      TH_W'(RATIO_NUM / 81),  TH_W'(RATIO_NUM / 83),  TH_W'(RATIO_NUM / 85),
      TH_W'(RATIO_NUM / 87),  TH_W'(RATIO_NUM / 89),  TH_W'(RATIO_NUM / 91),
      TH_W'(RATIO_NUM / 93),  TH_W'(RATIO_NUM / 95),  TH_W'(RATIO_NUM / 97),
      TH_W'(RATIO_NUM / 99),  TH_W'(RATIO_NUM / 101), TH_W'(RATIO_NUM / 103),
      TH_W'(RATIO_NUM / 105), TH_W'(RATIO_NUM / 107), TH_W'(RATIO_NUM / 109),
      TH_W'(RATIO_NUM / 111)
   };

   typedef enum logic [1:0] {
      MODE_HALF        = 2'd0,
      MODE_POGO        = 2'd1,
      MODE_NALR        = 2'd2,
      MODE_NALR_SCALED = 2'd3
   } hgp_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORMULA = 3'd0,
      CSR_SIM     = 3'd1,
      CSR_MASTER  = 3'd2,
      CSR_BASS    = 3'd3,
      CSR_TREBLE  = 3'd4
   } hgp_csr_idx_type;

   typedef struct packed {
      hgp_mode_type              formula_mode;
      logic                      simulation_mode;
      logic signed [TRIM_W-1:0]  master_trim;
      logic signed [TRIM_W-1:0]  bass_trim;
      logic signed [TRIM_W-1:0]  treble_trim;
   } hgp_cfg_type;

   // load strobes for the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } hgp_adv_type;

   // 3200 * k-factor, in the doubled nal-r numerator
   function automatic logic signed [NAL_X_W-1:0] kf_term(input logic [FREQ_W-1:0] f);
      logic signed [NAL_X_W-1:0] k;
      if (f <= FREQ_W'(F_LOW)) begin
         k = -19'sd54400;
      end else if (f <= FREQ_W'(F_MID)) begin
         k = -19'sd25600;
      end else if (f <= FREQ_W'(F_KHZ)) begin
         k = 19'sd3200;
      end else if (f <= FREQ_W'(F_2KHZ)) begin
         k = -19'sd3200;
      end else if (f <= FREQ_W'(F_TREBLE)) begin
         k = -19'sd6400;
      end else begin
         k = -19'sd12800;
      end
      return k;
   endfunction

endpackage

/* hdl/hgp_req_if.sv */
interface hgp_req_if;
   import hgp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FREQ_W-1:0]       frequency_hz;
   logic signed [DB_W-1:0]  left_loss;
   logic signed [DB_W-1:0]  right_loss;
   logic signed [DB_W-1:0]  left_pta;
   logic signed [DB_W-1:0]  right_pta;
   logic signed [DB_W-1:0]  left_range;
   logic signed [DB_W-1:0]  right_range;

   modport source (
      output valid, frequency_hz, left_loss, right_loss, left_pta, right_pta,
             left_range, right_range,
      input  ready
   );

   modport sink (
      input  valid, frequency_hz, left_loss, right_loss, left_pta, right_pta,
             left_range, right_range,
      output ready
   );
endinterface

/* hdl/hgp_rsp_if.sv */
interface hgp_rsp_if;
   import hgp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GAIN_W-1:0] left_gain;
   logic signed [GAIN_W-1:0] right_gain;
   logic [RATIO_W-1:0]       compression_ratio;

   modport source (
      output valid, left_gain, right_gain, compression_ratio,
      input  ready
   );

   modport sink (
      input  valid, left_gain, right_gain, compression_ratio,
      output ready
   );
endinterface

/* hdl/hgp_csr.sv */
module hgp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hgp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hgp_pkg::CSR_DATA_W-1:0]   csr_data,
   output hgp_pkg::hgp_cfg_type             cfg
);
   import hgp_pkg::*;

   hgp_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.formula_mode    <= MODE_NALR;
         cfg_ff.simulation_mode <= 1'b0;
         cfg_ff.master_trim     <= '0;
         cfg_ff.bass_trim       <= '0;
         cfg_ff.treble_trim     <= '0;
      end else if (csr_we) begin
         unique case (hgp_csr_idx_type'(csr_index))
            CSR_FORMULA: cfg_ff.formula_mode    <= hgp_mode_type'(csr_data[1:0]);
            CSR_SIM:     cfg_ff.simulation_mode <= csr_data[0];
            CSR_MASTER:  cfg_ff.master_trim     <= $signed(csr_data[TRIM_W-1:0]);
            CSR_BASS:    cfg_ff.bass_trim       <= $signed(csr_data[TRIM_W-1:0]);
            CSR_TREBLE:  cfg_ff.treble_trim     <= $signed(csr_data[TRIM_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

/* hdl/hgp_ear.sv */
module hgp_ear (
   input  logic                              clock,
   input  hgp_pkg::hgp_adv_type              adv,
   input  hgp_pkg::hgp_cfg_type              cfg,
   input  logic [hgp_pkg::FREQ_W-1:0]        freq,
   input  logic signed [hgp_pkg::DB_W-1:0]   loss,
   input  logic signed [hgp_pkg::DB_W-1:0]   pta,
   input  logic signed [hgp_pkg::DB_W-1:0]   trim_s3,
   output logic signed [hgp_pkg::GAIN_W-1:0] gain
);
   import hgp_pkg::*;

   // stage 1: nal-r numerator, half gain, simulated loss
   logic signed [NAL_X_W-1:0] pta_w, loss_w, x_in, x_ff;
   logic signed [DB_W:0]      half13;
   logic signed [DB_W-1:0]    half_in, half_s1_ff, half_s2_ff;
   logic signed [DB_W-1:0]    sim_in, sim_s1_ff, sim_s2_ff, sim_s3_ff;

   always_comb begin
      pta_w  = NAL_X_W'(pta);
      loss_w = NAL_X_W'(loss);
      x_in   = pta_w * 19'sd10 + loss_w * 19'sd62 + kf_term(freq) + 19'sd100;

      half13  = (DB_W+1)'(loss) + 13'sd1;
      half_in = DB_W'(half13 >>> 1);
      if (cfg.formula_mode == MODE_POGO) begin
         if (freq <= FREQ_W'(F_LOW)) begin
            half_in = half_in - DB_W'(POGO_LOW);
         end else if (freq <= FREQ_W'(F_MID)) begin
            half_in = half_in - DB_W'(POGO_MID);
         end
      end

      if (loss < 0) begin
         sim_in = '0;
      end else if (loss > DB_W'(SIM_CAP)) begin
         sim_in = -DB_W'(SIM_CAP);
      end else begin
         sim_in = -loss;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         x_ff       <= x_in;
         half_s1_ff <= half_in;
         sim_s1_ff  <= sim_in;
      end
   end

   // stage 2: divide by 200 with clamp to the nal-r cap
   logic [DIV25_IN_W-1:0]   y;
   logic [DIV25_PROD_W-1:0] prod25;
   logic [BASE_W-1:0]       base_in, base_ff;

   always_comb begin
      y      = x_ff[DIV25_IN_W+2:3];
      prod25 = DIV25_PROD_W'(y) * DIV25_PROD_W'(DIV25_MUL);
      if (x_ff < 0) begin
         base_in = '0;
      end else if (x_ff >= NAL_X_W'(NAL_SAT_X)) begin
         base_in = BASE_W'(GAIN_CAP);
      end else begin
         base_in = prod25[DIV25_SHIFT+BASE_W-1:DIV25_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         base_ff    <= base_in;
         half_s2_ff <= half_s1_ff;
         sim_s2_ff  <= sim_s1_ff;
      end
   end

   // stage 3: 1.05 scaling and formula select
   logic [SCALE_Z_W-1:0]   z;
   logic [DIV5_IN_W-1:0]   w;
   logic [DIV5_PROD_W-1:0] prod5;
   logic [BASE_W-1:0]      scaled, half_c, g_in, g_ff;

   always_comb begin
      z      = SCALE_Z_W'(base_ff) * 14'd21 + 14'd10;
      w      = z[SCALE_Z_W-1:2];
      prod5  = DIV5_PROD_W'(w) * DIV5_PROD_W'(DIV5_MUL);
      scaled = prod5[DIV5_SHIFT+BASE_W-1:DIV5_SHIFT];
      if (scaled > BASE_W'(GAIN_CAP)) begin
         scaled = BASE_W'(GAIN_CAP);
      end

      if (half_s2_ff < 0) begin
         half_c = '0;
      end else if (half_s2_ff > DB_W'(GAIN_CAP)) begin
         half_c = BASE_W'(GAIN_CAP);
      end else begin
         half_c = half_s2_ff[BASE_W-1:0];
      end

      case (cfg.formula_mode)
         MODE_HALF, MODE_POGO: g_in = half_c;
         MODE_NALR:            g_in = base_ff;
         default:              g_in = scaled;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         g_ff      <= g_in;
         sim_s3_ff <= sim_s2_ff;
      end
   end

   // stage 4: trims and final clamp, or the simulated loss in simulation mode
   logic signed [DB_W:0]     sum;
   logic signed [GAIN_W-1:0] gain_in, gain_ff;

   always_comb begin
      sum = $signed({3'b000, g_ff}) + (DB_W+1)'(trim_s3);
      if (cfg.simulation_mode) begin
         gain_in = sim_s3_ff;
      end else if (sum < 0) begin
         gain_in = '0;
      end else if (sum > 13'(GAIN_MAX)) begin
         gain_in = GAIN_W'(GAIN_MAX);
      end else begin
         gain_in = sum[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         gain_ff <= gain_in;
      end
   end

   assign gain = gain_ff;
endmodule

/* hdl/hgp_ratio.sv */
module hgp_ratio (
   input  logic                             clock,
   input  hgp_pkg::hgp_adv_type             adv,
   input  hgp_pkg::hgp_cfg_type             cfg,
   input  logic signed [hgp_pkg::DB_W-1:0]  left_range,
   input  logic signed [hgp_pkg::DB_W-1:0]  right_range,
   output logic [hgp_pkg::RATIO_W-1:0]      ratio
);
   import hgp_pkg::*;

   // stage 1: smaller range against the threshold table
   logic signed [DB_W-1:0] r;
   logic [N_TH-1:0]        therm_in, therm_ff;
   logic                   zero_in, zero_ff, neg_in, neg_ff;

   always_comb begin
      r       = (left_range < right_range) ? left_range : right_range;
      zero_in = (r == 0);
      neg_in  = r[DB_W-1];
      for (int i = 0; i < N_TH; i++) begin
         therm_in[i] = (r[TH_W-1:0] <= RATIO_TH[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         therm_ff <= therm_in;
         zero_ff  <= zero_in;
         neg_ff   <= neg_in;
      end
   end

   // stage 2: thermometer to ratio
   logic [RATIO_W-1:0] cnt, ratio_in, ratio_s2_ff, ratio_s3_ff, ratio_ff;

   always_comb begin
      cnt = '0;
      for (int i = 0; i < N_TH; i++) begin
         if (therm_ff[i]) begin
            cnt = RATIO_W'(i + 1);
         end
      end
      if (cfg.simulation_mode || neg_ff) begin
         ratio_in = RATIO_W'(RATIO_MIN);
      end else if (zero_ff) begin
         ratio_in = RATIO_W'(RATIO_MAX);
      end else begin
         ratio_in = RATIO_W'(RATIO_MIN) + cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         ratio_s2_ff <= ratio_in;
      end
      if (adv.s3) begin
         ratio_s3_ff <= ratio_s2_ff;
      end
      if (adv.s4) begin
         ratio_ff <= ratio_s3_ff;
      end
   end

   assign ratio = ratio_ff;
endmodule

/* hdl/hearing_gain_prescription.sv */
// throughput: one item per cycle while rsp is ready, set by the four-stage
// pipeline (numerator, divide by 200, 1.05 scale and formula select, trim
// and clamp); a stalled rsp holds the pipe; empty stages still fill while
// stalled
// reset: synchronous active high, clears valid bits and loads register defaults
module hearing_gain_prescription (
   input  logic                            clock,
   input  logic                            reset,
   hgp_req_if.sink                         req_if,
   hgp_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [hgp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hgp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hgp_pkg::*;

   hgp_cfg_type cfg;
   hgp_adv_type adv;

   // configuration registers
   hgp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // per-stage valid bits, stage 4 is the output register
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   always_comb begin
      // a stage loads when it is empty or its content moves on
      rdy4 = !v4_ff || rsp_if.ready;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;

      adv.s1 = rdy1;
      adv.s2 = rdy2;
      adv.s3 = rdy3;
      adv.s4 = rdy4;

      v1_in = rdy1 ? req_if.valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_if.ready = rdy1;
   assign rsp_if.valid = v4_ff;

   // band trim: master always, bass at or below 500 hz, treble from 4 khz up
   logic signed [DB_W-1:0] trim_in, trim_s1_ff, trim_s2_ff, trim_s3_ff;

   always_comb begin
      trim_in = DB_W'(cfg.master_trim);
      if (req_if.frequency_hz <= FREQ_W'(F_MID)) begin
         trim_in = trim_in + DB_W'(cfg.bass_trim);
      end
      if (req_if.frequency_hz >= FREQ_W'(F_TREBLE)) begin
         trim_in = trim_in + DB_W'(cfg.treble_trim);
      end
   end

   // trim travels alongside the ear pipelines until the trim stage
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         trim_s1_ff <= trim_in;
      end
      if (adv.s2) begin
         trim_s2_ff <= trim_s1_ff;
      end
      if (adv.s3) begin
         trim_s3_ff <= trim_s2_ff;
      end
   end

   // left and right ear gain pipelines
   hgp_ear u_ear_left (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg),
      .freq    (req_if.frequency_hz),
      .loss    (req_if.left_loss),
      .pta     (req_if.left_pta),
      .trim_s3 (trim_s3_ff),
      .gain    (rsp_if.left_gain)
   );

   hgp_ear u_ear_right (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg),
      .freq    (req_if.frequency_hz),
      .loss    (req_if.right_loss),
      .pta     (req_if.right_pta),
      .trim_s3 (trim_s3_ff),
      .gain    (rsp_if.right_gain)
   );

   // compression ratio from the smaller dynamic range
   hgp_ratio u_ratio (
      .clock       (clock),
      .adv         (adv),
      .cfg         (cfg),
      .left_range  (req_if.left_range),
      .right_range (req_if.right_range),
      .ratio       (rsp_if.compression_ratio)
   );

`ifndef SYNTHESIS
   // input only blocks when every stage is full and the output is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_if.ready))
      else $error("input stalled with room in the pipeline");

   // a held item in stage 3 is never dropped
   a_hold_s3: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy4) |=> v3_ff)
      else $error("stage 3 item lost under stall");

   // gains stay within the prescription and simulation bounds
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.left_gain >= -12'sd1120 && rsp_if.left_gain <= 12'sd560
                        && rsp_if.right_gain >= -12'sd1120
                        && rsp_if.right_gain <= 12'sd560))
      else $error("gain out of range");

   // ratio within 1.0 to 3.5
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.compression_ratio >= RATIO_W'(RATIO_MIN)
                        && rsp_if.compression_ratio <= RATIO_W'(RATIO_MAX)))
      else $error("compression ratio out of range");
`endif
endmodule
